// ----- rtl/rlpe_pkg.sv -----
// shared types, constants and reset values of the rgb led pulse encoder
package rlpe_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned PIX_BITS    = 3 * BYTE_W;
	localparam int unsigned SYMBOLS     = PIX_BITS;
	localparam int unsigned SYM_CNT_W   = $clog2(SYMBOLS);
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned QUEUE_DEPTH = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd3;

	localparam logic [BYTE_W-1:0] BRIGHTNESS_RST = 8'd255;
	localparam logic [BYTE_W-1:0] ZERO_HIGH_RST  = 8'd17;
	localparam logic [BYTE_W-1:0] ONE_HIGH_RST   = 8'd45;
	localparam logic [BYTE_W-1:0] PERIOD_RST     = 8'd63;

	// scaled pixel in wire order: green, red, blue, msb first
	typedef struct packed {
		logic [PIX_BITS-1:0] grb;
		logic                last;
	} pix_t;

	typedef struct packed {
		logic [BYTE_W-1:0] zero_high;
		logic [BYTE_W-1:0] one_high;
		logic [BYTE_W-1:0] period;
	} timing_t;

endpackage

// ----- rtl/rlpe_front.sv -----
// front end: accepts pixels and scales each byte by the brightness
module rlpe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  brightness,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic                        last_pixel,
	input  logic                        push,
	output logic                        full,
	output rlpe_pkg::pix_t              out_pix,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import rlpe_pkg::*;

	logic                   valid_s1;
	logic [2*BYTE_W-1:0]    prod_g_s1, prod_r_s1, prod_b_s1;
	logic                   last_s1;
	logic                   valid_s2;
	pix_t                   pix_s2;
	logic                   en_s1, en_s2;
	pix_t                   pix_d;

	// x / 255 for x below 255 * 256, where the quotient fits a byte: (x + (x >> 8) + 1) >> 8
	function automatic logic [BYTE_W-1:0] div255(input logic [2*BYTE_W-1:0] x);
		logic [2*BYTE_W:0] sum;
		sum = {1'b0, x} + {9'd0, x[2*BYTE_W-1:BYTE_W]} + 17'd1;
		return sum[2*BYTE_W-1:BYTE_W];
	endfunction

	assign en_s2 = !valid_s2 || out_ready;
	assign en_s1 = !valid_s1 || en_s2;
	assign full  = !en_s1;

	always_comb begin
		pix_d.grb  = {div255(prod_g_s1), div255(prod_r_s1), div255(prod_b_s1)};
		pix_d.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= push;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && push) begin
			prod_g_s1 <= {{BYTE_W{1'b0}}, green} * {{BYTE_W{1'b0}}, brightness};
			prod_r_s1 <= {{BYTE_W{1'b0}}, red} * {{BYTE_W{1'b0}}, brightness};
			prod_b_s1 <= {{BYTE_W{1'b0}}, blue} * {{BYTE_W{1'b0}}, brightness};
			last_s1   <= last_pixel;
		end
		if (en_s2 && valid_s1) pix_s2 <= pix_d;
	end

	assign out_pix   = pix_s2;
	assign out_valid = valid_s2;

endmodule

// ----- rtl/rlpe_queue.sv -----
// short queue of scaled pixels between front and back end
module rlpe_queue #(
	parameter int unsigned DEPTH = rlpe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rlpe_pkg::pix_t in_pix,
	input  logic           in_valid,
	output logic           in_ready,
	output rlpe_pkg::pix_t out_pix,
	output logic           out_valid,
	input  logic           out_ready
);
	import rlpe_pkg::*;

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pix_t             mem [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en, rd_en;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_pix   = mem[rd_ptr_q];

	function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd_en) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= in_pix;
	end

endmodule

// ----- rtl/rlpe_back.sv -----
// back end: shifts a pixel out as 24 timed bit symbols
module rlpe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rlpe_pkg::timing_t          timing,
	input  rlpe_pkg::pix_t             in_pix,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       empty,
	input  logic                       pop,
	output logic                       bit_value,
	output logic [7:0]                 high_cycles,
	output logic [7:0]                 low_cycles,
	output logic                       pixel_done,
	output logic                       frame_done
);
	import rlpe_pkg::*;

	logic                 busy_q;
	logic [PIX_BITS-1:0]  shift_q;
	logic [SYM_CNT_W-1:0] cnt_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic                 adv, finish, load;
	logic                 sym_bit, sym_pdone;
	logic [BYTE_W-1:0]    sym_hi, sym_lo;

	assign adv      = busy_q && (!out_valid_q || pop);
	assign finish   = adv && (cnt_q == SYM_CNT_W'(SYMBOLS - 1));
	assign in_ready = !busy_q || finish;
	assign load     = in_valid && in_ready;

	always_comb begin
		sym_bit   = shift_q[PIX_BITS-1];
		sym_hi    = sym_bit ? timing.one_high : timing.zero_high;
		sym_lo    = (timing.period > sym_hi) ? timing.period - sym_hi : '0;
		sym_pdone = cnt_q == SYM_CNT_W'(SYMBOLS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) busy_q <= 1'b1;
			else if (finish) busy_q <= 1'b0;
			if (load) cnt_q <= '0;
			else if (adv) cnt_q <= cnt_q + 1'b1;
			if (adv) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= in_pix.grb;
			last_q  <= in_pix.last;
		end else if (adv) begin
			shift_q <= {shift_q[PIX_BITS-2:0], 1'b0};
		end
		if (adv) begin
			bit_value   <= sym_bit;
			high_cycles <= sym_hi;
			low_cycles  <= sym_lo;
			pixel_done  <= sym_pdone;
			frame_done  <= sym_pdone && last_q;
		end
	end

	assign empty = !out_valid_q;

endmodule

// ----- rtl/rgb_led_pulse_encoder.sv -----
// top level of the rgb led pulse encoder: registers, front end, queue, back end
// the first symbol of a pixel reaches the result ports through both front end stages, the queue and the back end
// throughput: one symbol per cycle while pop takes each result and the queue has pixels, set by the back end shifter
// the two-stage front end (multiply, then divide by 255) and the queue let pixels overlap
// reset (arst_n low, asynchronous): queue and pipeline empty, registers back to
// brightness 255, zero high 17, one high 45, period 63
module rgb_led_pulse_encoder #(
	parameter int unsigned QUEUE_DEPTH = rlpe_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rlpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_wdata,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	input  logic                              last_pixel,
	input  logic                              push,
	output logic                              full,
	output logic                              empty,
	input  logic                              pop,
	output logic                              bit_value,
	output logic [7:0]                        high_cycles,
	output logic [7:0]                        low_cycles,
	output logic                              pixel_done,
	output logic                              frame_done
);
	import rlpe_pkg::*;

	// configuration registers; the user must write them only while the block is idle, the block itself does not enforce it
	logic [BYTE_W-1:0] brightness_q;
	timing_t           timing_q;

	// front end to queue
	pix_t front_pix;
	logic front_valid, front_ready;

	// queue to back end
	pix_t queue_pix;
	logic queue_valid, queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q       <= BRIGHTNESS_RST;
			timing_q.zero_high <= ZERO_HIGH_RST;
			timing_q.one_high  <= ONE_HIGH_RST;
			timing_q.period    <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: brightness_q       <= cfg_wdata;
				REG_ZERO_HIGH:  timing_q.zero_high <= cfg_wdata;
				REG_ONE_HIGH:   timing_q.one_high  <= cfg_wdata;
				REG_PERIOD:     timing_q.period    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scaling pipeline; full is high when its first stage holds a pixel that cannot move on
	rlpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.brightness (brightness_q),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.push       (push),
		.full       (full),
		.out_pix    (front_pix),
		.out_valid  (front_valid),
		.out_ready  (front_ready)
	);

	// decouples the scaler from the serialiser
	rlpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_pix    (front_pix),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_pix   (queue_pix),
		.out_valid (queue_valid),
		.out_ready (queue_ready)
	);

	// serialiser with its own output register, next pixel loaded on the last symbol
	rlpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.timing      (timing_q),
		.in_pix      (queue_pix),
		.in_valid    (queue_valid),
		.in_ready    (queue_ready),
		.empty       (empty),
		.pop         (pop),
		.bit_value   (bit_value),
		.high_cycles (high_cycles),
		.low_cycles  (low_cycles),
		.pixel_done  (pixel_done),
		.frame_done  (frame_done)
	);

endmodule

// ----- rtl/rlpe_checker.sv -----
// port-level checks of the rgb led pulse encoder and their binding
module rlpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       bit_value,
	input logic [7:0] high_cycles,
	input logic [7:0] low_cycles,
	input logic       pixel_done,
	input logic       frame_done
);

	// a frame ends only on the last symbol of a pixel
	a_frame_on_pixel_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_done |-> pixel_done)
		else $error("frame_done without pixel_done");

	// symbols of one pixel follow without gaps once one is taken
	a_symbols_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !pixel_done |=> !empty)
		else $error("gap inside a pixel");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before transfer");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(bit_value) && $stable(high_cycles) &&
			$stable(low_cycles) && $stable(pixel_done) && $stable(frame_done))
		else $error("result changed while stalled");

endmodule

bind rgb_led_pulse_encoder rlpe_checker u_rlpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.bit_value   (bit_value),
	.high_cycles (high_cycles),
	.low_cycles  (low_cycles),
	.pixel_done  (pixel_done),
	.frame_done  (frame_done)
);
